### hw/rtl/swls_pkg.sv
// Shared constants and types for the sliding-window latency statistics unit.
// No dependencies; used by swls_front, swls_back and the top level.
package swls_pkg;

    localparam int DEF_WINDOW      = 256;
    localparam int DEF_SAMPLE_BITS = 40;

    localparam int COUNT_BITS = 48;
    localparam int FRAC_BITS  = 8;

    // action codes
    localparam logic [1:0] ACT_RECORD = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // p99 rank = floor((99*w - 49) / 100), done as a reciprocal multiply
    localparam int P99_NUM   = 99;
    localparam int P99_BIAS  = 49;
    localparam int P99_SHIFT = 24;
    localparam int P99_RECIP = 167773;   // ceil(2^24 / 100)
    localparam int RECIP_BITS = 18;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic       valid;
        logic [1:0] act;
    } t_qhead;

endpackage

### hw/rtl/sliding_window_latency_stats_unit.sv
// Top level of the sliding-window latency statistics unit.
// Depends on swls_pkg, swls_front and swls_back.
//
// Usage:
//   Input channel: drive i_action and i_sample_ns with start high; the word
//   is taken at a rising edge where busy is low. Action 0 records a sample,
//   1 queries, 2 clears, 3 is taken and dropped.
//   Result channel: a query returns one word, shown for exactly one cycle
//   with o_strobe high. The receiver cannot stall; sample it on the strobe.
//   Timing: words pass through a two-entry command queue, so busy rises
//   only when two words wait. Record and clear are applied as they leave
//   the queue. A query over an empty window answers in the cycle after it
//   leaves the queue. Otherwise it runs a radix rank select (one pass over
//   the ring memory per sample bit, one read port) and then a bit-serial
//   division for the mean.
//   Reset (i_rst_n low, synchronous) empties the queue and the statistics;
//   the ring needs no clearing pass since only filled slots are read.
module sliding_window_latency_stats_unit #(
    parameter int WINDOW      = swls_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = swls_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       start,
    output logic                                       busy,
    input  logic [1:0]                                 i_action,
    input  logic [SAMPLE_BITS-1:0]                     i_sample_ns,
    output logic                                       o_strobe,
    output logic [swls_pkg::COUNT_BITS-1:0]            o_total_count,
    output logic [$clog2(WINDOW+1)-1:0]                o_window_fill,
    output logic [SAMPLE_BITS-1:0]                     o_last_ns,
    output logic [SAMPLE_BITS-1:0]                     o_min_ns,
    output logic [SAMPLE_BITS-1:0]                     o_max_ns,
    output logic [SAMPLE_BITS+swls_pkg::FRAC_BITS-1:0] o_mean_q8_ns,
    output logic [SAMPLE_BITS-1:0]                     o_median_ns,
    output logic [SAMPLE_BITS-1:0]                     o_p99_ns
);
    // queue head and payload handed from front to back
    swls_pkg::t_qhead       head;
    logic [SAMPLE_BITS-1:0] head_sample;
    logic                   pop;

    swls_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_action (i_action),
        .i_sample (i_sample_ns),
        .i_pop    (pop),
        .o_head   (head),
        .o_sample (head_sample)
    );

    swls_back #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FW          ($clog2(WINDOW + 1))
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_sample      (head_sample),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_total_count (o_total_count),
        .o_window_fill (o_window_fill),
        .o_last_ns     (o_last_ns),
        .o_min_ns      (o_min_ns),
        .o_max_ns      (o_max_ns),
        .o_mean_q8_ns  (o_mean_q8_ns),
        .o_median_ns   (o_median_ns),
        .o_p99_ns      (o_p99_ns)
    );

endmodule

### hw/rtl/swls_front.sv
// Command front end: accepts words, drops unused codes, queues the rest.
// Depends on swls_pkg.
module swls_front #(
    parameter int SAMPLE_BITS = swls_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_action,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_pop,
    output swls_pkg::t_qhead       o_head,
    output logic [SAMPLE_BITS-1:0] o_sample
);
    logic [1:0]             r_act [2];
    logic [SAMPLE_BITS-1:0] r_smp [2];
    logic                   r_wp;
    logic                   r_rp;
    logic [1:0]             r_cnt;
    logic                   push;
    logic                   pop;

    assign busy = (r_cnt == 2'd2);
    // drop the unused code at the door
    assign push = start && !busy && (i_action != swls_pkg::ACT_NONE);
    assign pop  = i_pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.act   = r_act[r_rp];
    assign o_sample     = r_smp[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_act[r_wp] <= i_action;
            r_smp[r_wp] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            if (push && !pop)      r_cnt <= r_cnt + 2'd1;
            else if (pop && !push) r_cnt <= r_cnt - 2'd1;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");

endmodule

### hw/rtl/swls_back.sv
// Back end: sample ring, counters, radix rank select and mean divider.
// Depends on swls_pkg.
module swls_back #(
    parameter int WINDOW      = swls_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = swls_pkg::DEF_SAMPLE_BITS,
    parameter int FW          = $clog2(WINDOW + 1)
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  swls_pkg::t_qhead                          i_head,
    input  logic [SAMPLE_BITS-1:0]                    i_sample,
    output logic                                      o_pop,
    output logic                                      o_strobe,
    output logic [swls_pkg::COUNT_BITS-1:0]           o_total_count,
    output logic [FW-1:0]                             o_window_fill,
    output logic [SAMPLE_BITS-1:0]                    o_last_ns,
    output logic [SAMPLE_BITS-1:0]                    o_min_ns,
    output logic [SAMPLE_BITS-1:0]                    o_max_ns,
    output logic [SAMPLE_BITS+swls_pkg::FRAC_BITS-1:0] o_mean_q8_ns,
    output logic [SAMPLE_BITS-1:0]                    o_median_ns,
    output logic [SAMPLE_BITS-1:0]                    o_p99_ns
);
    localparam int SB   = SAMPLE_BITS;
    localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int BW   = $clog2(SB);
    localparam int SUMW = SB + FW;
    localparam int DW   = SUMW + swls_pkg::FRAC_BITS;
    localparam int CW   = $clog2(DW);
    localparam int XW   = $clog2(swls_pkg::P99_NUM * WINDOW + 1);
    localparam int PW   = XW + swls_pkg::RECIP_BITS;
    localparam int MW   = SB + swls_pkg::FRAC_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RANK = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [SB-1:0] mem [WINDOW];
    logic [SB-1:0] r_rd;

    logic [1:0]                     r_state;
    logic [AW-1:0]                  r_wi;
    logic [FW-1:0]                  r_fill;
    logic [swls_pkg::COUNT_BITS-1:0] r_total;
    logic [SB-1:0]                  r_last;

    logic [FW-1:0]  r_addr;
    logic           r_vld;
    logic [BW-1:0]  r_bit;
    logic [SB-1:0]  r_pm, r_pp, r_hm;
    logic [FW-1:0]  r_km, r_kp;
    logic [FW-1:0]  r_cm, r_cp;
    logic [XW-1:0]  r_x;
    logic [SB-1:0]  r_min, r_max;
    logic [SUMW-1:0] r_sum;
    logic [FW-1:0]  r_rem;
    logic [DW-1:0]  r_quo;
    logic [CW-1:0]  r_dcnt;
    logic [MW-1:0]  r_mean;
    logic           r_strobe;

    logic           wr_en;
    logic           first;
    logic           hit_m, hit_p;
    logic [FW:0]    rem_sh;
    logic           qbit;
    logic [PW-1:0]  prod;
    logic [SB-1:0]  bitmask;

    assign o_pop = (r_state == ST_IDLE) && i_head.valid;
    assign wr_en = o_pop && (i_head.act == swls_pkg::ACT_RECORD);
    assign first = (r_bit == BW'(SB - 1));
    assign bitmask = SB'(1) << r_bit;
    assign hit_m = (((r_rd ^ r_pm) & r_hm) == '0) && !r_rd[r_bit];
    assign hit_p = (((r_rd ^ r_pp) & r_hm) == '0) && !r_rd[r_bit];
    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign qbit   = (rem_sh >= {1'b0, r_fill});
    assign prod   = PW'(r_x) * PW'(swls_pkg::P99_RECIP);

    // ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_wi] <= i_sample;
        r_rd <= mem[r_addr[AW-1:0]];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (o_pop && i_head.act == swls_pkg::ACT_QUERY) begin
                    r_x    <= XW'(XW'(r_fill) * XW'(swls_pkg::P99_NUM)
                              - XW'(swls_pkg::P99_BIAS));
                    r_km   <= r_fill >> 1;
                    r_addr <= '0;
                    r_vld  <= 1'b0;
                    r_bit  <= BW'(SB - 1);
                    r_pm   <= '0;
                    r_pp   <= '0;
                    r_hm   <= '0;
                    r_cm   <= '0;
                    r_cp   <= '0;
                    r_min  <= '0;
                    r_max  <= '0;
                    r_sum  <= '0;
                    r_mean <= '0;
                end
            end
            ST_RANK: begin
                r_kp  <= prod[swls_pkg::P99_SHIFT +: FW];
                r_min <= '1;
            end
            ST_SCAN: begin
                if (r_addr < r_fill) begin
                    r_addr <= r_addr + FW'(1);
                    r_vld  <= 1'b1;
                end else begin
                    r_vld  <= 1'b0;
                end
                if (r_vld) begin
                    if (hit_m) r_cm <= r_cm + FW'(1);
                    if (hit_p) r_cp <= r_cp + FW'(1);
                    if (first) begin
                        if (r_rd < r_min) r_min <= r_rd;
                        if (r_rd > r_max) r_max <= r_rd;
                        r_sum <= r_sum + SUMW'(r_rd);
                    end
                end
                if (r_addr == r_fill && !r_vld) begin
                    // settle this bit of both ranks, move to the next bit
                    if (r_km >= r_cm) begin
                        r_pm <= r_pm | bitmask;
                        r_km <= r_km - r_cm;
                    end
                    if (r_kp >= r_cp) begin
                        r_pp <= r_pp | bitmask;
                        r_kp <= r_kp - r_cp;
                    end
                    r_hm   <= r_hm | bitmask;
                    r_cm   <= '0;
                    r_cp   <= '0;
                    r_addr <= '0;
                    r_bit  <= r_bit - BW'(1);
                    r_rem  <= '0;
                    r_quo  <= {r_sum, {swls_pkg::FRAC_BITS{1'b0}}};
                    r_dcnt <= CW'(DW - 1);
                end
            end
            ST_DIV: begin
                r_rem  <= qbit ? FW'(rem_sh - {1'b0, r_fill}) : rem_sh[FW-1:0];
                r_quo  <= {r_quo[DW-2:0], qbit};
                r_dcnt <= r_dcnt - CW'(1);
                if (r_dcnt == '0) r_mean <= MW'({r_quo[DW-2:0], qbit});
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wi     <= '0;
            r_fill   <= '0;
            r_total  <= '0;
            r_last   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        case (i_head.act)
                            swls_pkg::ACT_RECORD: begin
                                r_wi <= (r_wi == AW'(WINDOW - 1)) ? '0 : r_wi + AW'(1);
                                if (r_fill != FW'(WINDOW)) r_fill <= r_fill + FW'(1);
                                r_total <= r_total + swls_pkg::COUNT_BITS'(1);
                                r_last  <= i_sample;
                            end
                            swls_pkg::ACT_CLEAR: begin
                                r_wi    <= '0;
                                r_fill  <= '0;
                                r_total <= '0;
                                r_last  <= '0;
                            end
                            swls_pkg::ACT_QUERY: begin
                                if (r_fill == '0) r_strobe <= 1'b1;
                                else              r_state  <= ST_RANK;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RANK: r_state <= ST_SCAN;
                ST_SCAN: begin
                    if (r_addr == r_fill && !r_vld && r_bit == '0) r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_dcnt == '0) begin
                        r_state  <= ST_IDLE;
                        r_strobe <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_strobe      = r_strobe;
    assign o_total_count = r_total;
    assign o_window_fill = r_fill;
    assign o_last_ns     = r_last;
    assign o_min_ns      = r_min;
    assign o_max_ns      = r_max;
    assign o_mean_q8_ns  = r_mean;
    assign o_median_ns   = r_pm;
    assign o_p99_ns      = r_pp;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> r_state == ST_IDLE) else $error("result outside idle");
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(WINDOW)) else $error("fill above window");
    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_addr <= r_fill) else $error("scan past fill");
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |=> r_state == ST_DIV || o_strobe)
        else $error("divider left without result");

endmodule
